// File: rtl/hfa_pkg.sv
// hfa_pkg: shared constants and types for the half-precision adder
// no dependencies
package hfa_pkg;
  localparam logic [15:0] ExpMask   = 16'h7C00;
  localparam logic [4:0]  ExpMax    = 5'd31;

  // unpacked operand pair after alignment
  typedef struct packed {
    logic        sa;
    logic        sb;
    logic [4:0]  e;
    logic [10:0] ma;
    logic [10:0] mb;
  } align_t;

  typedef struct packed {
    logic        sign;
    logic [4:0]  e;
    logic [11:0] m;
  } sum_t;
endpackage

// File: rtl/hfa_norm.sv
// hfa_norm: leading-zero count of the raw mantissa sum below the carry bit
// no dependencies
module hfa_norm (
  input  logic [11:0] m_i,
  output logic [3:0]  lz_o
);
  always_comb begin
    lz_o = 4'd11;
    for (int i = 0; i <= 10; i++) begin
      if (m_i[i]) lz_o = 4'(10 - i);
    end
  end
endmodule

// File: rtl/half_float_adder_top.sv
// half_float_adder_top: binary16 adder, truncating, saturating to infinity
// depends on hfa_pkg and hfa_norm
//
// Four-stage pipeline: unpack/align, add/subtract, normalize, pack. One item
// is accepted every cycle (busy is always low) and each sum appears on
// sum_value_o from the pack-stage register, with done_o high alongside it;
// the receiver cannot stall, so nothing is held back.
module half_float_adder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  output logic        done_o,
  output logic [15:0] sum_value_o
);
  hfa_pkg::align_t al_d, al_q;
  hfa_pkg::sum_t   sm_d, sm_q;
  logic [3:0]  v_q;
  logic [11:0] mn_d, mn_q;
  logic signed [6:0] en_d, en_q;
  logic sn_q, zero_d, zero_q;
  logic [15:0] res_d, res_q;
  logic [3:0]  lz;

  assign busy = 1'b0;

  // stage 1: unpack and align
  always_comb begin
    logic [4:0] ea, eb;
    logic [10:0] ma, mb;
    ea = operand_a_i[14:10];
    eb = operand_b_i[14:10];
    ma = (ea == 5'd0) ? 11'd0 : {1'b1, operand_a_i[9:0]};
    mb = (eb == 5'd0) ? 11'd0 : {1'b1, operand_b_i[9:0]};
    al_d.sa = operand_a_i[15];
    al_d.sb = operand_b_i[15];
    if (ea > eb) begin
      al_d.e  = ea;
      al_d.ma = ma;
      al_d.mb = mb >> (ea - eb);
    end else begin
      al_d.e  = eb;
      al_d.mb = mb;
      al_d.ma = ma >> (eb - ea);
    end
  end

  // stage 2: add or subtract by sign
  always_comb begin
    sm_d.e = al_q.e;
    if (al_q.sa == al_q.sb) begin
      sm_d.m = {1'b0, al_q.ma} + {1'b0, al_q.mb};
      sm_d.sign = al_q.sa;
    end else if (al_q.ma >= al_q.mb) begin
      sm_d.m = {1'b0, al_q.ma - al_q.mb};
      sm_d.sign = al_q.sa;
    end else begin
      sm_d.m = {1'b0, al_q.mb - al_q.ma};
      sm_d.sign = al_q.sb;
    end
  end

  // stage 3: normalize
  hfa_norm u_norm (.m_i(sm_q.m), .lz_o(lz));

  always_comb begin
    zero_d = (sm_q.m == 12'd0);
    if (sm_q.m[11]) begin
      mn_d = sm_q.m >> 1;
      en_d = 7'(sm_q.e) + 7'sd1;
    end else begin
      mn_d = sm_q.m << lz;
      en_d = 7'(sm_q.e) - 7'(lz);
    end
  end

  // stage 4: pack with overflow and underflow
  always_comb begin
    if (zero_q || en_q <= 7'sd0) res_d = 16'd0;
    else if (en_q >= 7'(hfa_pkg::ExpMax))
      res_d = {sn_q, 15'd0} | hfa_pkg::ExpMask;
    else res_d = {sn_q, en_q[4:0], mn_q[9:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[2:0], start};
  end

  always_ff @(posedge clk_i) begin
    al_q   <= al_d;
    sm_q   <= sm_d;
    mn_q   <= mn_d;
    en_q   <= en_d;
    sn_q   <= sm_q.sign;
    zero_q <= zero_d;
    res_q  <= res_d;
  end

  assign done_o      = v_q[3];
  assign sum_value_o = res_q;
endmodule

// File: rtl/hfa_checker.sv
// hfa_checker: port-level assertions for the half-precision adder
// depends on half_float_adder_top ports
module hfa_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [15:0] sum_value_o
);
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start ##4 1'b1 |-> done_o) else $error("missing sum");
  a_nobusy: assert property (@(posedge clk_i) !busy) else $error("busy");
  a_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && sum_value_o[14:10] == 5'd31 |-> sum_value_o[9:0] == 10'd0)
    else $error("bad infinity");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && sum_value_o[14:10] == 5'd0 |-> sum_value_o == 16'd0)
    else $error("bad zero");
endmodule

bind half_float_adder_top hfa_sva u_hfa_sva (.*);
